/* design/tcl_pkg.sv */
// ----------------------------------------------------------------------------
// tcl_pkg: shared types and constants of the two-column tile layout
// Holds the configuration record, the divider request and response records,
// the sequencer state type, register indices, status codes and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package tcl_pkg;

	// Fixed widths of the datapath.
	localparam int SCR_W     = 16;          // screen and tile coordinates on the ports
	localparam int CRD_W     = 20;          // signed internal coordinate width
	localparam int PROD_W    = 25;          // signed width of the share product
	localparam int MAG_W     = PROD_W - 1;  // magnitude width seen by the divider
	localparam int DVS_W     = 7;           // divisor width (percent base or row count)
	localparam int IDX_W     = 6;           // tile index width
	localparam int REG_W     = 12;          // widest configuration register
	localparam int CFG_IDX_W = 3;           // configuration register index width

	// Divider: quotient bits produced per cycle and cycles per division.
	localparam int DIV_STEPS = 2;
	localparam int DIV_ITER  = MAG_W / DIV_STEPS;
	localparam int DIV_CNT_W = $clog2(DIV_ITER + 1);

	// Master share clamp limits and percent base.
	localparam logic [6:0] PCT_LO  = 7'd10;
	localparam logic [6:0] PCT_HI  = 7'd90;
	localparam logic [6:0] PCT_DIV = 7'd100;

	// Register values after reset.
	localparam logic [11:0] RST_TOP_BAR       = 12'd28;
	localparam logic [11:0] RST_BOTTOM_BAR    = 12'd34;
	localparam logic [9:0]  RST_OUTER_MARGIN  = 10'd10;
	localparam logic [9:0]  RST_INNER_SPACING = 10'd8;
	localparam logic [11:0] RST_MIN_W         = 12'd120;
	localparam logic [11:0] RST_MIN_H         = 12'd80;
	localparam logic [6:0]  RST_MASTER_SHARE  = 7'd50;

	typedef logic signed [CRD_W-1:0]  crd_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	// Configuration register indices.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOP_BAR       = 3'd0,
		REG_BOTTOM_BAR    = 3'd1,
		REG_OUTER_MARGIN  = 3'd2,
		REG_INNER_SPACING = 3'd3,
		REG_MIN_W         = 3'd4,
		REG_MIN_H         = 3'd5,
		REG_MASTER_SHARE  = 3'd6
	} cfg_reg_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_PLACED     = 2'd0,
		STAT_NO_WINDOWS = 2'd1,
		STAT_NO_SPACE   = 2'd2,
		STAT_TOO_SMALL  = 2'd3
	} status_t;

	typedef struct packed {
		logic [11:0] top_bar;
		logic [11:0] bottom_bar;
		logic [9:0]  outer_margin;
		logic [9:0]  inner_spacing;
		logic [11:0] min_w;
		logic [11:0] min_h;
		logic [6:0]  share;
	} cfg_t;

	typedef struct packed {
		logic             start;
		prod_t            dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic  done;
		prod_t quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_PCT_GO,
		S_PCT_WAIT,
		S_SPLIT,
		S_L_GO,
		S_L_WAIT,
		S_R_GO,
		S_R_WAIT,
		S_FIT,
		S_EMIT,
		S_STATUS
	} seq_state_t;

endpackage

`default_nettype wire

/* design/tcl_cfg_regs.sv */
// ----------------------------------------------------------------------------
// tcl_cfg_regs: configuration register file
// Seven write-only registers, each masked to its width; writes to an index
// beyond the list are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module tcl_cfg_regs import tcl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// Register writes, one index per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.top_bar       <= RST_TOP_BAR;
			cfg_q.bottom_bar    <= RST_BOTTOM_BAR;
			cfg_q.outer_margin  <= RST_OUTER_MARGIN;
			cfg_q.inner_spacing <= RST_INNER_SPACING;
			cfg_q.min_w         <= RST_MIN_W;
			cfg_q.min_h         <= RST_MIN_H;
			cfg_q.share         <= RST_MASTER_SHARE;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_TOP_BAR:       cfg_q.top_bar       <= cfg_data;
				REG_BOTTOM_BAR:    cfg_q.bottom_bar    <= cfg_data;
				REG_OUTER_MARGIN:  cfg_q.outer_margin  <= cfg_data[9:0];
				REG_INNER_SPACING: cfg_q.inner_spacing <= cfg_data[9:0];
				REG_MIN_W:         cfg_q.min_w         <= cfg_data;
				REG_MIN_H:         cfg_q.min_h         <= cfg_data;
				REG_MASTER_SHARE:  cfg_q.share         <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* design/tcl_divider.sv */
// ----------------------------------------------------------------------------
// tcl_divider: shared iterative divider
// Signed dividend by a positive divisor, quotient truncated toward zero.
// Restoring division on the magnitude, two quotient bits per cycle, with the
// sign put back at the end. A start pulse loads the operands; done pulses
// for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module tcl_divider import tcl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DVS_W-1:0]     rem_q;
	logic [MAG_W-1:0]     quo_q;

	prod_t            abs_full;
	logic [MAG_W-1:0] mag;
	logic [DVS_W-1:0] rem_nx;
	logic [MAG_W-1:0] quo_nx;
	logic [DVS_W:0]   trial;
	prod_t            quo_pos;

	// Magnitude of the incoming dividend.
	always_comb begin
		abs_full = req.dividend[PROD_W-1] ? -req.dividend : req.dividend;
		mag      = abs_full[MAG_W-1:0];
	end

	// Two restoring steps per cycle: shift a dividend bit into the remainder,
	// subtract the divisor where it fits.
	always_comb begin
		rem_nx = rem_q;
		quo_nx = quo_q;
		trial  = '0;
		for (int k = 0; k < DIV_STEPS; k++) begin
			trial = {rem_nx, quo_nx[MAG_W-1]};
			if (trial >= {1'b0, dvs_q}) begin
				rem_nx = DVS_W'(trial - {1'b0, dvs_q});
				quo_nx = {quo_nx[MAG_W-2:0], 1'b1};
			end else begin
				rem_nx = trial[DVS_W-1:0];
				quo_nx = {quo_nx[MAG_W-2:0], 1'b0};
			end
		end
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_ITER);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial result registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= mag;
			rem_q <= '0;
			dvs_q <= req.divisor;
			neg_q <= req.dividend[PROD_W-1];
		end else if (busy_q) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

	// Restore the sign of the quotient.
	always_comb begin
		quo_pos      = $signed({1'b0, quo_q});
		rsp.done     = done_q;
		rsp.quotient = neg_q ? -quo_pos : quo_pos;
	end

endmodule

`default_nettype wire

/* design/tcl_sequencer.sv */
// ----------------------------------------------------------------------------
// tcl_sequencer: layout sequencer, column datapath and result register
// Takes one request, derives the workspace and the two columns, runs the master
// share (two or more windows) and row heights through the shared divider, then
// checks minimum sizes, walks rows, one tile word per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module tcl_sequencer import tcl_pkg::*; #(
	parameter int MAX_WINDOWS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic [SCR_W-1:0] screen_w,
	input  logic [SCR_W-1:0] screen_h,
	input  logic [7:0]       window_count,
	output div_req_t         div_req,
	input  div_rsp_t         div_rsp,
	output logic             res_valid,
	input  logic             res_ready,
	output logic [IDX_W-1:0] tile_index,
	output logic [SCR_W-1:0] x_pos,
	output logic [SCR_W-1:0] y_pos,
	output logic [SCR_W-1:0] tile_w,
	output logic [SCR_W-1:0] tile_h,
	output logic             last_tile,
	output status_t          status
);

	localparam int CW = $clog2(MAX_WINDOWS + 1);

	function automatic crd_t to_crd(input logic [SCR_W-1:0] v);
		return crd_t'({{(CRD_W-SCR_W){1'b0}}, v});
	endfunction

	seq_state_t state_q, state_d;

	// Request and column registers.
	logic [CW-1:0] count_q;
	crd_t          ws_w_q, ws_h_q, usable_q, lw_q;
	prod_t         prod_q;
	logic [CW-1:0] ln_q, rn_q;
	crd_t          lx_q, ly_q, lcw_q, lch_q;
	crd_t          rx_q, ry_q, rcw_q, rch_q;
	crd_t          num_l_q, num_r_q, each_l_q, each_r_q;
	status_t       stat_q;

	// Row walk registers.
	logic             side_q;
	logic [CW-1:0]    row_q;
	crd_t             top_q;
	logic [IDX_W-1:0] idx_q;

	// Result register.
	logic             res_valid_q;
	logic [IDX_W-1:0] tile_index_q;
	logic [SCR_W-1:0] x_pos_q, y_pos_q, tile_w_q, tile_h_q;
	logic             last_tile_q;
	status_t          status_q;

	// Combinational helpers.
	logic [CW-1:0] count_sat;
	crd_t          ws_x, ws_y, gap, min_w, min_h;
	crd_t          ws_w_in, ws_h_in;
	logic [6:0]    pct_cl;
	crd_t          usable_d;
	prod_t         usable_ext, pct_ext, prod_d;
	crd_t          rw_d, gr_l, gr_r;
	logic          ws_empty, fits;
	crd_t          cx, cy, cw, ch, each_c, h_t;
	logic [CW-1:0] n_c;
	logic          last_row, final_tile, tile_ok, slot_free;

	// Workspace geometry and clamped share.
	always_comb begin
		count_sat = (window_count > 8'(MAX_WINDOWS)) ? CW'(MAX_WINDOWS) : CW'(window_count);
		gap       = to_crd(SCR_W'(cfg.inner_spacing));
		min_w     = to_crd(SCR_W'(cfg.min_w));
		min_h     = to_crd(SCR_W'(cfg.min_h));
		ws_x      = to_crd(SCR_W'(cfg.outer_margin));
		ws_y      = to_crd(SCR_W'(cfg.top_bar)) + ws_x;
		ws_w_in   = to_crd(screen_w) - ws_x - ws_x;
		ws_h_in   = to_crd(screen_h) - to_crd(SCR_W'(cfg.top_bar))
		            - to_crd(SCR_W'(cfg.bottom_bar)) - ws_x - ws_x;
		ws_empty  = (ws_w_q <= 0) || (ws_h_q <= 0);

		if (cfg.share < PCT_LO) begin
			pct_cl = PCT_LO;
		end else if (cfg.share > PCT_HI) begin
			pct_cl = PCT_HI;
		end else begin
			pct_cl = cfg.share;
		end
		usable_d   = ws_w_q - gap;
		usable_ext = prod_t'(usable_d);
		pct_ext    = prod_t'(pct_cl);
		prod_d     = usable_ext * pct_ext;

		// Right column width and the gap total inside each column.
		rw_d = usable_q - lw_q;
		gr_l = to_crd(16'(cfg.inner_spacing) * 16'(ln_q - CW'(1)));
		gr_r = to_crd(16'(cfg.inner_spacing) * 16'(rn_q - CW'(1)));

		// Minimum size check over both columns, the right one only when it has rows.
		fits = !((each_l_q < min_h) || (lcw_q < min_w));
		if (rn_q != '0) begin
			fits = fits && !((each_r_q < min_h) || (rcw_q < min_w));
		end
	end

	// Current tile of the row walk.
	always_comb begin
		cx     = side_q ? rx_q : lx_q;
		cy     = side_q ? ry_q : ly_q;
		cw     = side_q ? rcw_q : lcw_q;
		ch     = side_q ? rch_q : lch_q;
		each_c = side_q ? each_r_q : each_l_q;
		n_c    = side_q ? rn_q : ln_q;

		last_row   = (row_q == n_c - CW'(1));
		final_tile = last_row && (side_q || (rn_q == '0));
		h_t        = last_row ? (cy + ch - top_q) : each_c;
		tile_ok    = (cw > 0) && (h_t > 0);
		slot_free  = !res_valid_q || res_ready;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				priority if (count_q == '0 || ws_empty) begin
					state_d = S_STATUS;
				end else if (count_q == CW'(1)) begin
					state_d = S_L_GO;
				end else begin
					state_d = S_PCT_GO;
				end
			end
			S_PCT_GO: state_d = S_PCT_WAIT;
			S_PCT_WAIT: begin
				if (div_rsp.done) begin
					state_d = S_SPLIT;
				end
			end
			S_SPLIT: state_d = S_L_GO;
			S_L_GO:  state_d = S_L_WAIT;
			S_L_WAIT: begin
				if (div_rsp.done) begin
					state_d = (rn_q != '0) ? S_R_GO : S_FIT;
				end
			end
			S_R_GO: state_d = S_R_WAIT;
			S_R_WAIT: begin
				if (div_rsp.done) begin
					state_d = S_FIT;
				end
			end
			S_FIT: state_d = fits ? S_EMIT : S_STATUS;
			S_EMIT: begin
				if (slot_free && final_tile) begin
					state_d = S_IDLE;
				end
			end
			S_STATUS: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Handshake and divider requests.
	always_comb begin
		req_ready        = (state_q == S_IDLE);
		div_req.start    = 1'b0;
		div_req.dividend = prod_q;
		div_req.divisor  = PCT_DIV;
		unique case (state_q)
			S_PCT_GO: begin
				div_req.start = 1'b1;
			end
			S_L_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = prod_t'(num_l_q);
				div_req.divisor  = DVS_W'(ln_q);
			end
			S_R_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = prod_t'(num_r_q);
				div_req.divisor  = DVS_W'(rn_q);
			end
			default: begin
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == S_EMIT || state_q == S_STATUS) && slot_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Datapath and result payload.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					count_q <= count_sat;
					ws_w_q  <= ws_w_in;
					ws_h_q  <= ws_h_in;
				end
			end
			S_CHECK: begin
				usable_q <= usable_d;
				prod_q   <= prod_d;
				stat_q   <= (count_q == '0) ? STAT_NO_WINDOWS : STAT_NO_SPACE;
				if (count_q == CW'(1)) begin
					// A single window uses the whole workspace as one column.
					ln_q    <= CW'(1);
					rn_q    <= '0;
					lx_q    <= ws_x;
					ly_q    <= ws_y;
					lcw_q   <= ws_w_q;
					lch_q   <= ws_h_q;
					num_l_q <= ws_h_q;
				end else begin
					ln_q <= count_q >> 1;
					rn_q <= count_q - (count_q >> 1);
				end
			end
			S_PCT_WAIT: begin
				if (div_rsp.done) begin
					lw_q <= div_rsp.quotient[CRD_W-1:0];
				end
			end
			S_SPLIT: begin
				// A column with no width collapses to an empty rectangle.
				if (lw_q > 0) begin
					lx_q    <= ws_x;
					ly_q    <= ws_y;
					lcw_q   <= lw_q;
					lch_q   <= ws_h_q;
					num_l_q <= ws_h_q - gr_l;
				end else begin
					lx_q    <= '0;
					ly_q    <= '0;
					lcw_q   <= '0;
					lch_q   <= '0;
					num_l_q <= -gr_l;
				end
				if (rw_d > 0) begin
					rx_q    <= ws_x + lw_q + gap;
					ry_q    <= ws_y;
					rcw_q   <= rw_d;
					rch_q   <= ws_h_q;
					num_r_q <= ws_h_q - gr_r;
				end else begin
					rx_q    <= '0;
					ry_q    <= '0;
					rcw_q   <= '0;
					rch_q   <= '0;
					num_r_q <= -gr_r;
				end
			end
			S_L_WAIT: begin
				if (div_rsp.done) begin
					each_l_q <= div_rsp.quotient[CRD_W-1:0];
				end
			end
			S_R_WAIT: begin
				if (div_rsp.done) begin
					each_r_q <= div_rsp.quotient[CRD_W-1:0];
				end
			end
			S_FIT: begin
				side_q <= 1'b0;
				row_q  <= '0;
				top_q  <= ly_q;
				idx_q  <= '0;
				stat_q <= STAT_TOO_SMALL;
			end
			S_EMIT: begin
				if (slot_free) begin
					tile_index_q <= idx_q;
					x_pos_q      <= tile_ok ? cx[SCR_W-1:0] : '0;
					y_pos_q      <= tile_ok ? top_q[SCR_W-1:0] : '0;
					tile_w_q     <= tile_ok ? cw[SCR_W-1:0] : '0;
					tile_h_q     <= tile_ok ? h_t[SCR_W-1:0] : '0;
					last_tile_q  <= final_tile;
					status_q     <= STAT_PLACED;
					idx_q        <= idx_q + IDX_W'(1);
					if (last_row) begin
						side_q <= 1'b1;
						row_q  <= '0;
						top_q  <= ry_q;
					end else begin
						row_q <= row_q + CW'(1);
						top_q <= top_q + each_c + gap;
					end
				end
			end
			S_STATUS: begin
				if (slot_free) begin
					tile_index_q <= '0;
					x_pos_q      <= '0;
					y_pos_q      <= '0;
					tile_w_q     <= '0;
					tile_h_q     <= '0;
					last_tile_q  <= 1'b1;
					status_q     <= stat_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid  = res_valid_q;
	assign tile_index = tile_index_q;
	assign x_pos      = x_pos_q;
	assign y_pos      = y_pos_q;
	assign tile_w     = tile_w_q;
	assign tile_h     = tile_h_q;
	assign last_tile  = last_tile_q;
	assign status     = status_q;

endmodule

`default_nettype wire

/* design/two_column_tile_layout_core.sv */
// ----------------------------------------------------------------------------
// two_column_tile_layout_core: master/stack tiling of a screen into tiles
// Splits the workspace left by the bars and margins into two columns of equal
// rows (bar the last) and returns one tile word per window, up to MAX_WINDOWS,
// left column first, or a single status word when no layout is possible.
//
//   channel  direction  handshake              payload
//   request  in         req_valid / req_ready  screen_w, screen_h, window_count
//   result   out        res_valid / res_ready  tile_index, x_pos, y_pos, tile_w,
//                                              tile_h, last_tile, status
//   config   in         cfg_write              cfg_index, cfg_data
//
// A request with two or more windows makes three passes through the shared
// divider, at two quotient bits per cycle; a single window needs one pass.
// The request side is not ready while a request is in work. A stalled result
// holds the row walk; the next request is taken while the last word waits.
// Reset loads the register defaults and empties the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module two_column_tile_layout_core import tcl_pkg::*; #(
	parameter int MAX_WINDOWS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic [SCR_W-1:0]     screen_w,
	input  logic [SCR_W-1:0]     screen_h,
	input  logic [7:0]           window_count,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic [IDX_W-1:0]     tile_index,
	output logic [SCR_W-1:0]     x_pos,
	output logic [SCR_W-1:0]     y_pos,
	output logic [SCR_W-1:0]     tile_w,
	output logic [SCR_W-1:0]     tile_h,
	output logic                 last_tile,
	output logic [1:0]           status
);

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;
	status_t  status_int;

	// Configuration registers.
	tcl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Shared divider for the share split and both row heights.
	tcl_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer with the column datapath and the result register.
	tcl_sequencer #(
		.MAX_WINDOWS (MAX_WINDOWS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.screen_w     (screen_w),
		.screen_h     (screen_h),
		.window_count (window_count),
		.div_req      (div_req),
		.div_rsp      (div_rsp),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.tile_index   (tile_index),
		.x_pos        (x_pos),
		.y_pos        (y_pos),
		.tile_w       (tile_w),
		.tile_h       (tile_h),
		.last_tile    (last_tile),
		.status       (status_int)
	);

	assign status = status_int;

endmodule

`default_nettype wire
